// ===== rtl/jep_pkg.sv =====
`default_nettype none

package jep_pkg;

    localparam int MAX_PEOPLE = 64;
    localparam int IDX_W      = $clog2(MAX_PEOPLE);
    localparam int CNT_W      = 7;
    localparam int STEP_W     = 10;
    localparam int DIV_CNT_W  = $clog2(STEP_W);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ===== rtl/josephus_elimination_order.sv =====
// sequence: build the ring, then per removal reduce (step-1) mod remaining in
// the divider, walk the ring (S_WALK then S_WALK_DATA per hop), raise the result
// in S_WALK, hand it over in S_EMIT and unlink; the winner follows the last unlink
// throughput: one problem at a time, item_ready high only while idle;
// the ring memory port (one read, one write a cycle) sets the hop rate
// reset: control state cleared, ring memory contents undefined until rebuilt
`default_nettype none

module josephus_elimination_order
    import jep_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire logic [CNT_W-1:0]  people_count,
    input  wire logic [STEP_W-1:0] step,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [CNT_W-1:0]       person,
    output logic                   is_winner
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_MOD,
        S_WALK,
        S_WALK_DATA,
        S_EMIT,
        S_UNLINK,
        S_WIN
    } state_t;

    state_t              state_reg, state_next;
    cnt_t                n_reg, n_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STEP_W-1:0]   dividend_reg, dividend_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    cnt_t                rem_reg, rem_next;
    idx_t                hops_reg, hops_next;
    idx_t                build_idx_reg, build_idx_next;
    idx_t                cursor_reg, cursor_next;
    idx_t                behind_cursor_reg, behind_cursor_next;
    cnt_t                remaining_reg, remaining_next;
    logic                result_valid_reg, result_valid_next;
    cnt_t                person_reg, person_next;
    logic                is_winner_reg, is_winner_next;

    idx_t                ring [MAX_PEOPLE];
    idx_t                rd_data_reg;
    logic                ring_we;
    idx_t                ring_waddr;
    idx_t                ring_wdata;

    cnt_t                n_in;
    logic [CNT_W:0]      shifted;
    logic [CNT_W:0]      reduced;
    cnt_t                build_plus1;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign person       = person_reg;
    assign is_winner    = is_winner_reg;

    // ring memory, read address follows the cursor
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[ring_waddr] <= ring_wdata;
        end
        rd_data_reg <= ring[cursor_reg];
    end

    always_comb
    begin
        if (people_count == '0)
            n_in = cnt_t'(1);
        else if (people_count > cnt_t'(MAX_PEOPLE))
            n_in = cnt_t'(MAX_PEOPLE);
        else
            n_in = people_count;
    end

    assign shifted     = {rem_reg, dividend_reg[STEP_W-1]};
    assign reduced     = shifted - {1'b0, remaining_reg};
    assign build_plus1 = {1'b0, build_idx_reg} + cnt_t'(1);

    always_comb
    begin
        state_next         = state_reg;
        n_next             = n_reg;
        step_next          = step_reg;
        dividend_next      = dividend_reg;
        div_cnt_next       = div_cnt_reg;
        rem_next           = rem_reg;
        hops_next          = hops_reg;
        build_idx_next     = build_idx_reg;
        cursor_next        = cursor_reg;
        behind_cursor_next = behind_cursor_reg;
        remaining_next     = remaining_reg;
        result_valid_next  = result_valid_reg;
        person_next        = person_reg;
        is_winner_next     = is_winner_reg;
        ring_we            = 1'b0;
        ring_waddr         = build_idx_reg;
        ring_wdata         = (build_plus1 < n_reg) ? build_plus1[IDX_W-1:0] : '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    n_next         = n_in;
                    step_next      = (step == '0) ? '0 : step - STEP_W'(1);
                    build_idx_next = '0;
                    state_next     = S_BUILD;
                end
            end
            S_BUILD:
            begin
                ring_we        = 1'b1;
                build_idx_next = build_plus1[IDX_W-1:0];
                if (build_plus1 == n_reg)
                begin
                    cursor_next        = '0;
                    behind_cursor_next = idx_t'(n_reg - cnt_t'(1));
                    remaining_next     = n_reg;
                    if (n_reg > cnt_t'(1))
                    begin
                        dividend_next = step_reg;
                        div_cnt_next  = DIV_CNT_W'(STEP_W - 1);
                        rem_next      = '0;
                        state_next    = S_MOD;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        person_next       = cnt_t'(1);
                        is_winner_next    = 1'b1;
                        state_next        = S_WIN;
                    end
                end
            end
            // restoring remainder, one dividend bit a cycle
            S_MOD:
            begin
                dividend_next = {dividend_reg[STEP_W-2:0], 1'b0};
                if (shifted >= {1'b0, remaining_reg})
                    rem_next = reduced[CNT_W-1:0];
                else
                    rem_next = shifted[CNT_W-1:0];
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    hops_next  = (shifted >= {1'b0, remaining_reg}) ?
                                 reduced[IDX_W-1:0] : shifted[IDX_W-1:0];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hops_reg == '0)
                begin
                    result_valid_next = 1'b1;
                    person_next       = {1'b0, cursor_reg} + cnt_t'(1);
                    is_winner_next    = 1'b0;
                    state_next        = S_EMIT;
                end
                else
                begin
                    state_next = S_WALK_DATA;
                end
            end
            S_WALK_DATA:
            begin
                behind_cursor_next = cursor_reg;
                cursor_next        = rd_data_reg;
                hops_next          = hops_reg - idx_t'(1);
                state_next         = S_WALK;
            end
            S_EMIT:
            begin
                if (result_ready)
                begin
                    result_valid_next = 1'b0;
                    state_next        = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                ring_we        = 1'b1;
                ring_waddr     = behind_cursor_reg;
                ring_wdata     = rd_data_reg;
                cursor_next    = rd_data_reg;
                remaining_next = remaining_reg - cnt_t'(1);
                if (remaining_reg > cnt_t'(2))
                begin
                    dividend_next = step_reg;
                    div_cnt_next  = DIV_CNT_W'(STEP_W - 1);
                    rem_next      = '0;
                    state_next    = S_MOD;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    person_next       = {1'b0, rd_data_reg} + cnt_t'(1);
                    is_winner_next    = 1'b1;
                    state_next        = S_WIN;
                end
            end
            S_WIN:
            begin
                if (result_ready)
                begin
                    result_valid_next = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cursor_reg        <= '0;
            behind_cursor_reg <= '0;
            remaining_reg     <= '0;
            result_valid_reg  <= 1'b0;
            person_reg        <= '0;
            is_winner_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cursor_reg        <= cursor_next;
            behind_cursor_reg <= behind_cursor_next;
            remaining_reg     <= remaining_next;
            result_valid_reg  <= result_valid_next;
            person_reg        <= person_next;
            is_winner_reg     <= is_winner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        step_reg      <= step_next;
        dividend_reg  <= dividend_next;
        div_cnt_reg   <= div_cnt_next;
        rem_reg       <= rem_next;
        hops_reg      <= hops_next;
        build_idx_reg <= build_idx_next;
    end

endmodule

`default_nettype wire
